### rtl/hcc_pkg.sv
// Shared types, constants and round functions for the HChaCha20 subkey core.
`default_nettype none

package hcc_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  // each quarter-round is split in two halves, each half a pipeline stage
  localparam int unsigned STAGES = 4 * DOUBLE_ROUNDS;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] state_t;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646E;
  localparam word_t SIGMA_2 = 32'h7962_2D32;
  localparam word_t SIGMA_3 = 32'h6B20_6574;

  localparam int unsigned ROT_A1 = 16;
  localparam int unsigned ROT_B1 = 12;
  localparam int unsigned ROT_A2 = 8;
  localparam int unsigned ROT_B2 = 7;

  function automatic word_t rotl(input word_t w, input int unsigned n);
    rotl = (w << n) | (w >> (32 - n));
  endfunction

  // One half of a quarter-round on all four lanes: column or diagonal, first or second half.
  function automatic state_t half_step(input state_t s, input logic diag, input logic second);
    state_t      o;
    int unsigned ia;
    int unsigned ib;
    int unsigned ic;
    int unsigned id;
    int unsigned ra;
    int unsigned rb;
    int unsigned sh;
    word_t       a;
    word_t       b;
    word_t       c;
    word_t       d;
    o  = s;
    ra = second ? ROT_A2 : ROT_A1;
    rb = second ? ROT_B2 : ROT_B1;
    sh = diag ? 1 : 0;
    for (int unsigned q = 0; q < 4; q++) begin
      ia = q;
      ib = 4 + ((q + sh) % 4);
      ic = 8 + ((q + 2 * sh) % 4);
      id = 12 + ((q + 3 * sh) % 4);
      a  = s[ia];
      b  = s[ib];
      c  = s[ic];
      d  = s[id];
      a  = a + b;
      d  = rotl(d ^ a, ra);
      c  = c + d;
      b  = rotl(b ^ c, rb);
      o[ia] = a;
      o[ib] = b;
      o[ic] = c;
      o[id] = d;
    end
    half_step = o;
  endfunction

endpackage

`default_nettype wire

### rtl/hchacha20_subkey_derive.sv
// Top level: pipelined HChaCha20 subkey derivation, one word per cycle unless stalled.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_key_0..3, in_nonce_0..1 (64 b each)
//   out     | output    | out_valid/out_stall | out_subkey_0..3 (64 b each)
//
// A word can enter every cycle the pipe is not held and passes one stage per half
// of a round, 40 halves over 20 rounds (ten column/diagonal double rounds).
// Throughput is one word per cycle unless stalled; the stage depth is two 32-bit adds.
// Reset clears the valid bits only; data registers are not reset.
// When the last stage holds a word and out_stall is high, the whole pipe
// holds and in_stall is raised in the same cycle.
`default_nettype none

module hchacha20_subkey_derive (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_key_0,
  input  wire logic [63:0] in_key_1,
  input  wire logic [63:0] in_key_2,
  input  wire logic [63:0] in_key_3,
  input  wire logic [63:0] in_nonce_0,
  input  wire logic [63:0] in_nonce_1,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_subkey_0,
  output logic [63:0]      out_subkey_1,
  output logic [63:0]      out_subkey_2,
  output logic [63:0]      out_subkey_3
);

  localparam int unsigned LAST = hcc_pkg::STAGES - 1;

  hcc_pkg::state_t             init_state;
  hcc_pkg::state_t             stage_r [hcc_pkg::STAGES];
  logic [hcc_pkg::STAGES-1:0]  vld_r;
  logic                        advance;

  assign advance  = !(vld_r[LAST] && out_stall);
  assign in_stall = !advance;

  always_comb begin
    init_state[0]  = hcc_pkg::SIGMA_0;
    init_state[1]  = hcc_pkg::SIGMA_1;
    init_state[2]  = hcc_pkg::SIGMA_2;
    init_state[3]  = hcc_pkg::SIGMA_3;
    init_state[4]  = in_key_0[31:0];
    init_state[5]  = in_key_0[63:32];
    init_state[6]  = in_key_1[31:0];
    init_state[7]  = in_key_1[63:32];
    init_state[8]  = in_key_2[31:0];
    init_state[9]  = in_key_2[63:32];
    init_state[10] = in_key_3[31:0];
    init_state[11] = in_key_3[63:32];
    init_state[12] = in_nonce_0[31:0];
    init_state[13] = in_nonce_0[63:32];
    init_state[14] = in_nonce_1[31:0];
    init_state[15] = in_nonce_1[63:32];
  end

  // valid bits shift along with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  for (genvar k = 0; k < hcc_pkg::STAGES; k++) begin : g_stage
    localparam logic DIAG   = ((k / 2) % 2) == 1;
    localparam logic SECOND = (k % 2) == 1;
    hcc_pkg::state_t stage_in;

    if (k == 0) begin : g_first
      assign stage_in = init_state;
    end else begin : g_next
      assign stage_in = stage_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage_r[k] <= hcc_pkg::half_step(stage_in, DIAG, SECOND);
      end
    end
  end

  assign out_valid    = vld_r[LAST];
  assign out_subkey_0 = {stage_r[LAST][1], stage_r[LAST][0]};
  assign out_subkey_1 = {stage_r[LAST][3], stage_r[LAST][2]};
  assign out_subkey_2 = {stage_r[LAST][13], stage_r[LAST][12]};
  assign out_subkey_3 = {stage_r[LAST][15], stage_r[LAST][14]};

endmodule

`default_nettype wire

### rtl/hcc_checker.sv
// Port-level checker for the HChaCha20 subkey core, bound to the top level.
`default_nettype none

module hcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_subkey_0,
  input wire logic [63:0] out_subkey_3
);

  // input side holds exactly when a finished word is held at the output
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output backpressure");

  // a new output word only appears after the pipe moved
  a_rise_after_move: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_stall))
    else $error("output word appeared while pipe held");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_subkey_0) && $stable(out_subkey_3))
    else $error("held output word changed");

endmodule

bind hchacha20_subkey_derive hcc_checker u_hcc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_subkey_0 (out_subkey_0),
  .out_subkey_3 (out_subkey_3)
);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the pipelined HChaCha20 subkey derivation core.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    logic [63:0] key_0;
    logic [63:0] key_1;
    logic [63:0] key_2;
    logic [63:0] key_3;
    logic [63:0] nonce_0;
    logic [63:0] nonce_1;
  } derive_req_t;

  typedef struct packed {
    logic [63:0] subkey_0;
    logic [63:0] subkey_1;
    logic [63:0] subkey_2;
    logic [63:0] subkey_3;
  } subkey_t;

  localparam int unsigned N_RANDOM    = 1450;
  localparam int unsigned DRAIN_FIRST = 300;
  localparam int unsigned DRAIN_LAST  = 900;
  localparam int unsigned TAIL_CYCLES = 4 * hcc_pkg::STAGES;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_key_0 = '0;
  logic [63:0] in_key_1 = '0;
  logic [63:0] in_key_2 = '0;
  logic [63:0] in_key_3 = '0;
  logic [63:0] in_nonce_0 = '0;
  logic [63:0] in_nonce_1 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_subkey_0;
  logic [63:0] out_subkey_1;
  logic [63:0] out_subkey_2;
  logic [63:0] out_subkey_3;

  derive_req_t req_q[$];
  subkey_t     subkey_exp_q[$];
  derive_req_t cur_req;
  int unsigned sent_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned directed_cnt = 0;
  int unsigned drain_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b0;
  bit          next_valid;

  hchacha20_subkey_derive u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_key_0     (in_key_0),
    .in_key_1     (in_key_1),
    .in_key_2     (in_key_2),
    .in_key_3     (in_key_3),
    .in_nonce_0   (in_nonce_0),
    .in_nonce_1   (in_nonce_1),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_subkey_0 (out_subkey_0),
    .out_subkey_1 (out_subkey_1),
    .out_subkey_2 (out_subkey_2),
    .out_subkey_3 (out_subkey_3)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic hcc_pkg::word_t rol32(input hcc_pkg::word_t w, input int unsigned n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic hcc_pkg::state_t qr_mix(input hcc_pkg::state_t st, input int unsigned ia,
                                             input int unsigned ib, input int unsigned ic,
                                             input int unsigned id);
    hcc_pkg::word_t a;
    hcc_pkg::word_t b;
    hcc_pkg::word_t c;
    hcc_pkg::word_t d;
    a = st[ia];
    b = st[ib];
    c = st[ic];
    d = st[id];
    a = a + b;  d = rol32(d ^ a, hcc_pkg::ROT_A1);
    c = c + d;  b = rol32(b ^ c, hcc_pkg::ROT_B1);
    a = a + b;  d = rol32(d ^ a, hcc_pkg::ROT_A2);
    c = c + d;  b = rol32(b ^ c, hcc_pkg::ROT_B2);
    st[ia] = a;
    st[ib] = b;
    st[ic] = c;
    st[id] = d;
    return st;
  endfunction

  function automatic subkey_t derive_subkey(input derive_req_t r);
    hcc_pkg::state_t st;
    subkey_t         sk;
    st[0]  = hcc_pkg::SIGMA_0;
    st[1]  = hcc_pkg::SIGMA_1;
    st[2]  = hcc_pkg::SIGMA_2;
    st[3]  = hcc_pkg::SIGMA_3;
    st[4]  = r.key_0[31:0];    st[5]  = r.key_0[63:32];
    st[6]  = r.key_1[31:0];    st[7]  = r.key_1[63:32];
    st[8]  = r.key_2[31:0];    st[9]  = r.key_2[63:32];
    st[10] = r.key_3[31:0];    st[11] = r.key_3[63:32];
    st[12] = r.nonce_0[31:0];  st[13] = r.nonce_0[63:32];
    st[14] = r.nonce_1[31:0];  st[15] = r.nonce_1[63:32];
    for (int unsigned rnd = 0; rnd < hcc_pkg::DOUBLE_ROUNDS; rnd++) begin
      st = qr_mix(st, 0, 4, 8, 12);
      st = qr_mix(st, 1, 5, 9, 13);
      st = qr_mix(st, 2, 6, 10, 14);
      st = qr_mix(st, 3, 7, 11, 15);
      st = qr_mix(st, 0, 5, 10, 15);
      st = qr_mix(st, 1, 6, 11, 12);
      st = qr_mix(st, 2, 7, 8, 13);
      st = qr_mix(st, 3, 4, 9, 14);
    end
    sk.subkey_0 = {st[1], st[0]};
    sk.subkey_1 = {st[3], st[2]};
    sk.subkey_2 = {st[13], st[12]};
    sk.subkey_3 = {st[15], st[14]};
    return sk;
  endfunction

  // Mostly short gaps, a few long ones; none at all during a calm stretch.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sparse64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return ~(64'd1 << $urandom_range(0, 63));
    endcase
  endfunction

  task automatic add_req(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
                         input logic [63:0] k3, input logic [63:0] n0, input logic [63:0] n1);
    derive_req_t r;
    r.key_0   = k0;
    r.key_1   = k1;
    r.key_2   = k2;
    r.key_3   = k3;
    r.nonce_0 = n0;
    r.nonce_1 = n1;
    req_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: hold the word while stalled, then load the next after its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        subkey_exp_q.push_back(derive_subkey(cur_req));
        sent_cnt++;
        next_valid = 1'b0;
        if ($urandom_range(0, 149) == 0) src_calm = ~src_calm;
        src_gap = pick_gap(src_calm);
        if (sent_cnt == DRAIN_FIRST || sent_cnt == DRAIN_LAST) drain_cnt++;
      end
      if (!next_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if ((sent_cnt == DRAIN_FIRST || sent_cnt == DRAIN_LAST) &&
                     subkey_exp_q.size() != 0) begin
          // hold until the pipe has emptied
        end else if (req_q.size() != 0) begin
          cur_req = req_q.pop_front();
          in_key_0   <= cur_req.key_0;
          in_key_1   <= cur_req.key_1;
          in_key_2   <= cur_req.key_2;
          in_key_3   <= cur_req.key_3;
          in_nonce_0 <= cur_req.nonce_0;
          in_nonce_1 <= cur_req.nonce_1;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: check each accepted word against the oldest expectation; drive random output stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (subkey_exp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, actual %h %h %h %h", $time,
                   out_subkey_0, out_subkey_1, out_subkey_2, out_subkey_3);
        end else begin
          subkey_t exp_sk;
          exp_sk = subkey_exp_q.pop_front();
          check_field("subkey_0", exp_sk.subkey_0, out_subkey_0);
          check_field("subkey_1", exp_sk.subkey_1, out_subkey_1);
          check_field("subkey_2", exp_sk.subkey_2, out_subkey_2);
          check_field("subkey_3", exp_sk.subkey_3, out_subkey_3);
          checked_cnt++;
        end
      end
      if ($urandom_range(0, 299) == 0) snk_calm = ~snk_calm;
      if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) snk_gap = pick_gap(snk_calm);
      end
    end
  end

  initial begin
    // directed: extremes, alternating patterns, each field alone, key or nonce alone, half words, end bits, byte counts
    add_req('0, '0, '0, '0, '0, '0);
    add_req('1, '1, '1, '1, '1, '1);
    add_req({4{16'h5555}}, {4{16'h5555}}, {4{16'h5555}},
            {4{16'h5555}}, {4{16'h5555}}, {4{16'h5555}});
    add_req({4{16'hAAAA}}, {4{16'hAAAA}}, {4{16'hAAAA}},
            {4{16'hAAAA}}, {4{16'hAAAA}}, {4{16'hAAAA}});
    add_req('1, '0, '0, '0, '0, '0);
    add_req('0, '1, '0, '0, '0, '0);
    add_req('0, '0, '1, '0, '0, '0);
    add_req('0, '0, '0, '1, '0, '0);
    add_req('0, '0, '0, '0, '1, '0);
    add_req('0, '0, '0, '0, '0, '1);
    add_req('1, '1, '1, '1, '0, '0);
    add_req('0, '0, '0, '0, '1, '1);
    add_req(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
            64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF);
    add_req(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000,
            64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_0000_0000);
    add_req(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
            64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
    add_req(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908,
            64'h1716_1514_1312_1110, 64'h1F1E_1D1C_1B1A_1918,
            64'h4A00_0000_0900_0000, 64'h2759_4131_0000_0000);
    directed_cnt = req_q.size();
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 85)
        add_req(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64());
      else
        add_req(sparse64(), sparse64(), sparse64(), sparse64(), sparse64(), sparse64());
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid || subkey_exp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d derivations (%0d directed), %0d subkeys checked,",
             sent_cnt, directed_cnt, checked_cnt);
    $display("with random gaps and stalls on both sides and %0d full drains", drain_cnt);
    if (subkey_exp_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected subkeys never arrived", $time, subkey_exp_q.size());
    end
    if (err_cnt == 0) begin
      $display("[hchacha20_subkey_derive] OK");
    end else begin
      $display("[hchacha20_subkey_derive] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("[hchacha20_subkey_derive] ERROR");
    $finish;
  end

endmodule
